FILE: sv/vfsp_pkg.sv
// ----------------------------------------------------------------------------
// vfsp_pkg: shared constants, types and sine table for the V/f sine PWM unit
// Register indexes, reset values, multiplier widths and the quarter-wave
// sine table built at elaboration.
// ----------------------------------------------------------------------------
package vfsp_pkg;

  // Sine table resolution and frequency ceiling
  localparam int SINE_TABLE_BITS = 8;
  localparam int MAX_FREQ        = 2047;

  localparam int SINE_N     = 1 << SINE_TABLE_BITS;
  localparam int SINE_IDX_W = SINE_TABLE_BITS + 1;
  localparam int FREQ_W     = $clog2(MAX_FREQ + 1);

  // Output frequency field limit
  localparam int FREQ_OUT_MAX = 2047;

  // Shared bit-serial multiplier: 32 x 16 -> 48
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_C_W = $clog2(MUL_B_W);

  localparam logic [31:0] THIRD_TURN     = 32'h5555_5555;
  localparam logic [31:0] NEG_THIRD_TURN = 32'hAAAA_AAAB;
  localparam logic [63:0] Q30_ONE        = 64'd1073741824;

  // Configuration register indexes
  localparam logic [2:0] REG_START_HZ   = 3'd0;
  localparam logic [2:0] REG_STEP_HZ    = 3'd1;
  localparam logic [2:0] REG_TICKS_SEC  = 3'd2;
  localparam logic [2:0] REG_PHASE_STEP = 3'd3;
  localparam logic [2:0] REG_AMP_GAIN   = 3'd4;
  localparam logic [2:0] REG_AMP_OFFSET = 3'd5;
  localparam logic [2:0] REG_AMP_MAX    = 3'd6;
  localparam logic [2:0] REG_PWM_PERIOD = 3'd7;

  // Register reset values
  localparam logic [10:0] START_HZ_RST   = 11'd40;
  localparam logic [7:0]  STEP_HZ_RST    = 8'd5;
  localparam logic [15:0] TICKS_SEC_RST  = 16'd20000;
  localparam logic [31:0] PHASE_STEP_RST = 32'd214748;
  localparam logic [7:0]  AMP_GAIN_RST   = 8'd20;
  localparam logic [14:0] AMP_OFFSET_RST = 15'd3277;
  localparam logic [14:0] AMP_MAX_RST    = 15'd31457;
  localparam logic [15:0] PWM_PERIOD_RST = 16'd8499;
  localparam logic [15:0] DUTY_RST       = PWM_PERIOD_RST >> 1;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef logic [14:0] sine_lut_t [0:SINE_N];

  // Q0.15 quarter-wave entries from a Q30 odd 9th-order polynomial
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i <= SINE_N; i++) begin
      x = 64'(i) << (30 - SINE_TABLE_BITS);
      if (x > Q30_ONE) begin
        x = Q30_ONE;
      end
      x2 = (x * x) >> 30;
      s  = 64'd172270;
      s  = 64'd5026995 - ((x2 * s) >> 30);
      s  = 64'd85569306 - ((x2 * s) >> 30);
      s  = 64'd693598668 - ((x2 * s) >> 30);
      s  = 64'd1686629713 - ((x2 * s) >> 30);
      v  = (x * s) >> 30;
      v  = (v + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      lut[i] = v[14:0];
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

FILE: sv/vfsp_mul.sv
// ----------------------------------------------------------------------------
// vfsp_mul: bit-serial shift-and-add multiplier
// One multiplier bit per cycle; the product is ready when the one-cycle
// done pulse flags it.
// ----------------------------------------------------------------------------
module vfsp_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vfsp_pkg::MUL_A_W-1:0]  mcand,
  input  logic [vfsp_pkg::MUL_B_W-1:0]  mplier,
  output logic [vfsp_pkg::MUL_P_W-1:0]  product,
  output vfsp_pkg::mul_stat_t           stat
);
  import vfsp_pkg::*;

  logic [MUL_A_W-1:0] mcand_r;
  logic [MUL_C_W-1:0] cnt;
  logic               busy;
  logic               done;
  logic [MUL_A_W:0]   sum;

  // partial sum on the upper half; multiplier bits shift out of the bottom
  assign sum = {1'b0, product[MUL_P_W-1:MUL_B_W]} +
               (product[0] ? {1'b0, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        mcand_r <= mcand;
        product <= {{MUL_A_W{1'b0}}, mplier};
      end else if (busy) begin
        product <= {sum, product[MUL_B_W-1:1]};
        cnt     <= cnt + 1'b1;
        if (cnt == MUL_C_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: sv/vf_three_phase_sine_pwm_unit.sv
// ----------------------------------------------------------------------------
// vf_three_phase_sine_pwm_unit: open-loop V/f three-phase sine PWM generator
// Frequency ramp, phase accumulator, V/f amplitude and three compare values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, field tick): one transfer per PWM
//   period. tick = 1 advances the ramp, phase and amplitude and produces new
//   compare values; tick = 0 repeats the last result unchanged.
//   Output channel (out_valid / out_stall): one result per input transfer,
//   carrying duty_a/b/c, frequency_hz and amplitude.
//   Configuration: cfg_we writes cfg_data into register cfg_index; write only
//   while the unit is idle.
//   Sequencing: a tick = 1 item runs nine products through one shared
//   bit-serial multiplier plus three sine table reads; a tick = 0 item goes
//   straight to the output stage. The unit works on one item at a time;
//   in_stall is high while it is busy or in reset, and the next input
//   transfer can come at the same edge as the result transfer. The output
//   register lets the next item start while a result still waits.
//   Reset: registers take their default values, phase and counters clear,
//   all duties read pwm_period / 2 (default period), frequency and amplitude
//   read 0.
//   A stalled receiver holds the result; a finished item waits for the
//   output register to free up.
// ----------------------------------------------------------------------------
module vf_three_phase_sine_pwm_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] duty_a,
  output logic [15:0] duty_b,
  output logic [15:0] duty_c,
  output logic [10:0] frequency_hz,
  output logic [14:0] amplitude,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import vfsp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_POST = 3'd3;
  localparam logic [2:0] S_LUT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [2:0] OP_SEC   = 3'd0;
  localparam logic [2:0] OP_PHASE = 3'd1;
  localparam logic [2:0] OP_AMP   = 3'd2;
  localparam logic [2:0] OP_SINE  = 3'd3;
  localparam logic [2:0] OP_DUTY  = 3'd4;

  // configuration
  logic [10:0] cfg_start_hz;
  logic [7:0]  cfg_step_hz;
  logic [15:0] cfg_ticks_sec;
  logic [31:0] cfg_phase_step;
  logic [7:0]  cfg_amp_gain;
  logic [14:0] cfg_amp_offset;
  logic [14:0] cfg_amp_max;
  logic [15:0] cfg_pwm_period;

  // sequencer and state
  logic [2:0]        state;
  logic [2:0]        op;
  logic [1:0]        ph;
  logic              tick_r;
  logic [31:0]       acc;
  logic [15:0]       tick_count;
  logic [15:0]       seconds;
  logic [FREQ_W-1:0] f_r;
  logic [14:0]       amp_r;
  logic [14:0]       mag_r;
  logic              neg_r;
  logic [30:0]       frac_r;
  logic [15:0]       nd [0:2];

  // multiplier
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  mul_stat_t          mul_stat;

  // combinational helpers
  logic [31:0]           phase_off;
  logic [31:0]           phase_k;
  logic [SINE_IDX_W-1:0] lut_idx;
  logic [25:0]           sum_f;
  logic [25:0]           sum_a;
  logic [30:0]           frac_next;
  logic [15:0]           duty_raw;
  logic [16:0]           tick_inc;

  vfsp_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .product (prod),
    .stat    (mul_stat)
  );

  assign mul_start = (state == S_LOAD);
  assign in_stall  = rst || (state != S_IDLE);

  always_comb begin
    case (op)
      OP_SEC: begin
        mul_a = MUL_A_W'(cfg_step_hz);
        mul_b = MUL_B_W'(seconds);
      end
      OP_PHASE: begin
        mul_a = MUL_A_W'(cfg_phase_step);
        mul_b = MUL_B_W'(f_r);
      end
      OP_AMP: begin
        mul_a = MUL_A_W'(cfg_amp_gain);
        mul_b = MUL_B_W'(f_r);
      end
      OP_SINE: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(amp_r);
      end
      OP_DUTY: begin
        mul_a = MUL_A_W'(frac_r);
        mul_b = MUL_B_W'(cfg_pwm_period);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (ph)
      2'd1:    phase_off = THIRD_TURN;
      2'd2:    phase_off = NEG_THIRD_TURN;
      default: phase_off = '0;
    endcase
  end

  // quadrant in the top two bits; odd quadrants mirror the index
  assign phase_k = acc + phase_off;
  assign lut_idx = phase_k[30] ?
                   SINE_IDX_W'(SINE_N) - {1'b0, phase_k[29 -: SINE_TABLE_BITS]} :
                   {1'b0, phase_k[29 -: SINE_TABLE_BITS]};

  assign sum_f     = 26'(cfg_start_hz) + 26'(prod[23:0]);
  assign sum_a     = 26'(cfg_amp_offset) + 26'(prod[23:0]);
  assign frac_next = neg_r ? 31'(Q30_ONE) - 31'(prod[29:0]) :
                             31'(Q30_ONE) + 31'(prod[29:0]);
  assign duty_raw  = prod[46:31];
  assign tick_inc  = 17'(tick_count) + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_start_hz   <= START_HZ_RST;
      cfg_step_hz    <= STEP_HZ_RST;
      cfg_ticks_sec  <= TICKS_SEC_RST;
      cfg_phase_step <= PHASE_STEP_RST;
      cfg_amp_gain   <= AMP_GAIN_RST;
      cfg_amp_offset <= AMP_OFFSET_RST;
      cfg_amp_max    <= AMP_MAX_RST;
      cfg_pwm_period <= PWM_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_HZ:   cfg_start_hz   <= cfg_data[10:0];
        REG_STEP_HZ:    cfg_step_hz    <= cfg_data[7:0];
        REG_TICKS_SEC:  cfg_ticks_sec  <= cfg_data[15:0];
        REG_PHASE_STEP: cfg_phase_step <= cfg_data;
        REG_AMP_GAIN:   cfg_amp_gain   <= cfg_data[7:0];
        REG_AMP_OFFSET: cfg_amp_offset <= cfg_data[14:0];
        REG_AMP_MAX:    cfg_amp_max    <= cfg_data[14:0];
        REG_PWM_PERIOD: cfg_pwm_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_SEC;
      ph           <= '0;
      tick_r       <= 1'b0;
      out_valid    <= 1'b0;
      acc          <= '0;
      tick_count   <= '0;
      seconds      <= '0;
      duty_a       <= DUTY_RST;
      duty_b       <= DUTY_RST;
      duty_c       <= DUTY_RST;
      frequency_hz <= '0;
      amplitude    <= '0;
    end else begin
      // in S_OUT the output register is reloaded below instead
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tick_r <= tick;
            op     <= OP_SEC;
            ph     <= '0;
            state  <= tick ? S_LOAD : S_OUT;
          end
        end
        S_LOAD: state <= S_WAIT;
        S_WAIT: begin
          if (mul_stat.done) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          case (op)
            OP_SEC: begin
              f_r   <= (sum_f > 26'(MAX_FREQ)) ? FREQ_W'(MAX_FREQ) : sum_f[FREQ_W-1:0];
              op    <= OP_PHASE;
              state <= S_LOAD;
            end
            OP_PHASE: begin
              acc   <= acc + prod[31:0];
              op    <= OP_AMP;
              state <= S_LOAD;
            end
            OP_AMP: begin
              amp_r <= (sum_a > 26'(cfg_amp_max)) ? cfg_amp_max : sum_a[14:0];
              state <= S_LUT;
            end
            OP_SINE: begin
              frac_r <= frac_next;
              op     <= OP_DUTY;
              state  <= S_LOAD;
            end
            OP_DUTY: begin
              nd[ph] <= (duty_raw > cfg_pwm_period) ? cfg_pwm_period : duty_raw;
              if (ph == 2'd2) begin
                state <= S_OUT;
              end else begin
                ph    <= ph + 2'd1;
                state <= S_LUT;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_LUT: begin
          mag_r <= SINE_LUT[lut_idx];
          neg_r <= phase_k[31];
          op    <= OP_SINE;
          state <= S_LOAD;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (tick_r) begin
              duty_a       <= nd[0];
              duty_b       <= nd[1];
              duty_c       <= nd[2];
              frequency_hz <= (32'(f_r) > 32'(FREQ_OUT_MAX)) ? 11'(FREQ_OUT_MAX) : 11'(f_r);
              amplitude    <= amp_r;
              if (tick_inc >= 17'(cfg_ticks_sec)) begin
                tick_count <= '0;
                if (seconds != 16'hFFFF) begin
                  seconds <= seconds + 16'd1;
                end
              end else begin
                tick_count <= tick_inc[15:0];
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a tick transfer always starts the multiply sequence
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && tick) |=> (state == S_LOAD))
    else $error("tick transfer did not start the sequence");

  // waiting on the multiplier only while it runs or just finished
  a_wait_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (mul_stat.busy || mul_stat.done))
    else $error("waiting on an idle multiplier");

  // the seconds count never goes backward
  a_seconds_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (seconds >= $past(seconds)))
    else $error("seconds count decreased");
`endif

endmodule
